>>> hdl/image_rotate_bilinear_defines.svh
// Assertion macros used by the checker file.
`ifndef IMAGE_ROTATE_BILINEAR_DEFINES_SVH
`define IMAGE_ROTATE_BILINEAR_DEFINES_SVH

// Implication on the same edge, masked during reset.
`define IRB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irb check failed");

// Implication onto the next edge, masked during reset.
`define IRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irb check failed");

// Next-edge implication that also runs through reset.
`define IRB_ASSERT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("irb check failed");

`endif

>>> hdl/irb_pkg.sv
`timescale 1ns / 1ps
package irb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 16;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_EMIT    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ROW_LENGTH = 3'd2;
    localparam logic [2:0] REG_COS_STEP   = 3'd3;
    localparam logic [2:0] REG_SIN_STEP   = 3'd4;
    localparam logic [2:0] REG_START_X    = 3'd5;
    localparam logic [2:0] REG_START_Y    = 3'd6;

    // One queued job: a store write or a destination pixel.
    typedef struct packed {
        logic        is_load;
        logic [7:0]  col;      // load column or floor(x)
        logic [7:0]  row;      // load row or floor(y)
        logic [23:0] pixel;
        logic [15:0] fx;
        logic [15:0] fy;
        logic        ok;
        logic [11:0] dcol;
        logic [15:0] drow;
        logic        last;
    } t_job;

endpackage

>>> hdl/irb_if.sv
`timescale 1ns / 1ps
interface irb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  load_col;
    logic [7:0]  load_row;
    logic [23:0] load_pixel;
    modport source (output valid, opcode, load_col, load_row, load_pixel, input ready);
    modport sink   (input valid, opcode, load_col, load_row, load_pixel, output ready);
endinterface

interface irb_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] out_pixel;
    logic        in_range;
    logic [11:0] dest_col;
    logic [15:0] dest_row;
    logic        row_end;
    modport source (output valid, out_pixel, in_range, dest_col, dest_row, row_end,
                    input ready);
    modport sink   (input valid, out_pixel, in_range, dest_col, dest_row, row_end,
                    output ready);
endinterface

>>> hdl/irb_front.sv
`timescale 1ns / 1ps
module irb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    irb_in_if.sink            s_in,
    input  logic              i_full,
    output logic              o_push,
    output irb_pkg::t_job     o_job
);
    logic [8:0]  r_src_w, r_src_h;
    logic [12:0] r_row_len;
    logic [31:0] r_cos, r_sin, r_start_x, r_start_y;
    logic [31:0] r_row_x, r_row_y, r_pix_x, r_pix_y;
    logic [11:0] r_col;
    logic [15:0] r_row;

    logic        accept, last, ok;
    logic [8:0]  w, h;
    logic [12:0] len;
    logic [15:0] ix, iy;

    assign s_in.ready = !i_full;
    assign accept     = s_in.valid && !i_full;

    always_comb begin
        w   = (r_src_w > 9'd256) ? 9'd256 : r_src_w;
        h   = (r_src_h > 9'd256) ? 9'd256 : r_src_h;
        len = (r_row_len == 13'd0) ? 13'd1 : ((r_row_len > 13'd4096) ? 13'd4096 : r_row_len);
        last = ({1'b0, r_col} + 13'd1) >= len;
        ix = r_pix_x[31:16];
        iy = r_pix_y[31:16];
        ok = !r_pix_x[31] && !r_pix_y[31] && (w >= 9'd2) && (h >= 9'd2)
             && (ix < {7'd0, w - 9'd1}) && (iy < {7'd0, h - 9'd1});
    end

    always_comb begin
        o_job.is_load = (s_in.opcode == irb_pkg::OP_LOAD);
        o_job.col     = o_job.is_load ? s_in.load_col : ix[7:0];
        o_job.row     = o_job.is_load ? s_in.load_row : iy[7:0];
        o_job.pixel   = s_in.load_pixel;
        o_job.fx      = r_pix_x[15:0];
        o_job.fy      = r_pix_y[15:0];
        o_job.ok      = ok;
        o_job.dcol    = r_col;
        o_job.drow    = r_row;
        o_job.last    = last;
        o_push = accept && (s_in.opcode == irb_pkg::OP_LOAD
                            || s_in.opcode == irb_pkg::OP_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 9'd256;  r_src_h <= 9'd256;  r_row_len <= 13'd256;
            r_cos <= 32'd65536; r_sin <= 32'd0;
            r_start_x <= 32'd0; r_start_y <= 32'd0;
            r_row_x <= 32'd0; r_row_y <= 32'd0; r_pix_x <= 32'd0; r_pix_y <= 32'd0;
            r_col <= 12'd0; r_row <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    irb_pkg::REG_SRC_WIDTH:  r_src_w   <= i_cfg_data[8:0];
                    irb_pkg::REG_SRC_HEIGHT: r_src_h   <= i_cfg_data[8:0];
                    irb_pkg::REG_ROW_LENGTH: r_row_len <= i_cfg_data[12:0];
                    irb_pkg::REG_COS_STEP:   r_cos <= {{14{i_cfg_data[17]}}, i_cfg_data[17:0]};
                    irb_pkg::REG_SIN_STEP:   r_sin <= {{14{i_cfg_data[17]}}, i_cfg_data[17:0]};
                    irb_pkg::REG_START_X:    r_start_x <= i_cfg_data;
                    irb_pkg::REG_START_Y:    r_start_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && s_in.opcode == irb_pkg::OP_RESTART) begin
                r_row_x <= r_start_x; r_pix_x <= r_start_x;
                r_row_y <= r_start_y; r_pix_y <= r_start_y;
                r_col <= 12'd0; r_row <= 16'd0;
            end else if (accept && s_in.opcode == irb_pkg::OP_EMIT) begin
                if (last) begin
                    r_row_x <= r_row_x - r_sin; r_pix_x <= r_row_x - r_sin;
                    r_row_y <= r_row_y + r_cos; r_pix_y <= r_row_y + r_cos;
                    r_col <= 12'd0;
                    r_row <= r_row + 16'd1;
                end else begin
                    r_pix_x <= r_pix_x + r_cos;
                    r_pix_y <= r_pix_y + r_sin;
                    r_col <= r_col + 12'd1;
                end
            end
        end
    end
endmodule

>>> hdl/irb_fifo.sv
`timescale 1ns / 1ps
module irb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  irb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output irb_pkg::t_job o_job
);
    irb_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

>>> hdl/irb_bank.sv
`timescale 1ns / 1ps
module irb_bank (
    input  logic        i_clk,
    input  logic        i_we,
    input  logic [13:0] i_waddr,
    input  logic [23:0] i_wdata,
    input  logic [13:0] i_raddr,
    output logic [23:0] o_rdata
);
    logic [23:0] r_mem [16384];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hdl/irb_back.sv
`timescale 1ns / 1ps
module irb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  irb_pkg::t_job i_job,
    output logic          o_pop,
    irb_out_if.source     m_out
);
    typedef enum logic [1:0] {S_IDLE, S_RD, S_MUL} t_state;

    t_state        r_state;
    irb_pkg::t_job r_job, j;
    logic [23:0]   rdata [4];
    logic [13:0]   raddr [4];
    logic [23:0]   r_p [4];     // p00, p01, p10, p11
    logic [33:0]   r_w [4];
    logic          r_out_valid;
    logic [23:0]   r_out_pixel;
    logic          r_out_ok, r_out_last;
    logic [11:0]   r_out_col;
    logic [15:0]   r_out_row;
    logic          wr, out_free;
    logic [16:0]   ifx, ify;
    logic [23:0]   blend_pix;

    assign j        = (r_state == S_IDLE) ? i_job : r_job;
    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign wr       = o_pop && i_job.is_load;
    assign out_free = !r_out_valid || m_out.ready;

    // Parity bank b = {row parity, col parity}; pick the neighbor row/col with that parity.
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic [7:0] rr, cc;
            rr = (j.row[0] == b[1]) ? j.row : j.row + 8'd1;
            cc = (j.col[0] == b[0]) ? j.col : j.col + 8'd1;
            raddr[b] = {rr[7:1], cc[7:1]};
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        irb_bank u_bank (
            .i_clk  (i_clk),
            .i_we   (wr && ({i_job.row[0], i_job.col[0]} == g[1:0])),
            .i_waddr({i_job.row[7:1], i_job.col[7:1]}),
            .i_wdata(i_job.pixel),
            .i_raddr(raddr[g]),
            .o_rdata(rdata[g])
        );
    end

    assign ifx = 17'h10000 - {1'b0, r_job.fx};
    assign ify = 17'h10000 - {1'b0, r_job.fy};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [41:0] s;
            s = r_w[0] * r_p[0][c*8 +: 8] + r_w[1] * r_p[1][c*8 +: 8]
              + r_w[2] * r_p[2][c*8 +: 8] + r_w[3] * r_p[3][c*8 +: 8]
              + 42'h0_8000_0000;
            blend_pix[c*8 +: 8] = (s[41:32] > 10'd255) ? 8'hFF : s[39:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Output slot: loaded by the blend step, freed by the sink.
            if (r_state == S_MUL && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && !i_job.is_load) begin
                        r_job   <= i_job;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_p[0] <= rdata[{r_job.row[0],  r_job.col[0]}];
                    r_p[1] <= rdata[{r_job.row[0], ~r_job.col[0]}];
                    r_p[2] <= rdata[{~r_job.row[0], r_job.col[0]}];
                    r_p[3] <= rdata[{~r_job.row[0], ~r_job.col[0]}];
                    r_w[0] <= ifx * ify;
                    r_w[1] <= {1'b0, r_job.fx} * ify;
                    r_w[2] <= ifx * {1'b0, r_job.fy};
                    r_w[3] <= {1'b0, r_job.fx} * {1'b0, r_job.fy};
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (out_free) begin
                        r_out_pixel <= r_job.ok ? blend_pix : 24'd0;
                        r_out_ok    <= r_job.ok;
                        r_out_col   <= r_job.dcol;
                        r_out_row   <= r_job.drow;
                        r_out_last  <= r_job.last;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_out.valid     = r_out_valid;
    assign m_out.out_pixel = r_out_pixel;
    assign m_out.in_range  = r_out_ok;
    assign m_out.dest_col  = r_out_col;
    assign m_out.dest_row  = r_out_row;
    assign m_out.row_end   = r_out_last;
endmodule

>>> hdl/image_rotate_bilinear.sv
`timescale 1ns / 1ps
// Path: a pixel passes the queue, then bank read, weight multiply and blend in the
//   back end sequencer, then the output register; a load is written to its bank
//   from the queue. No new job leaves the queue until a pixel is through the blend;
//   the input never waits while the 2-entry queue has room.
// Reset: i_rst_n synchronous active low; clears control, queue and config to defaults.
//   The frame store is not cleared; every entry must be loaded before it is read.
module image_rotate_bilinear (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    irb_in_if.sink      s_in,
    irb_out_if.source   m_out
);
    // Front: config registers, coordinate walk, range test.
    // Queue: decouples input acceptance from the store/blend back end.
    // Back: four parity banks give the 2x2 neighborhood in one read.
    logic          push, full, q_valid, pop;
    irb_pkg::t_job push_job, q_job;

    irb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_in      (s_in),
        .i_full    (full),
        .o_push    (push),
        .o_job     (push_job)
    );

    irb_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_job  (q_job)
    );

    irb_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_job  (q_job),
        .o_pop  (pop),
        .m_out  (m_out)
    );
endmodule

>>> hdl/irb_checker.sv
`timescale 1ns / 1ps
`include "image_rotate_bilinear_defines.svh"
module irb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_in_range,
    input logic [23:0] i_out_pixel
);
    `IRB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_pixel))
    `IRB_ASSERT_IMPL(a_oor_zero, i_clk, i_rst_n, i_out_valid && !i_in_range, i_out_pixel == 24'd0)
    `IRB_ASSERT_RAW(a_rst_idle, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind image_rotate_bilinear irb_checker u_irb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(m_out.valid),
    .i_out_ready(m_out.ready),
    .i_in_range (m_out.in_range),
    .i_out_pixel(m_out.out_pixel)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

    // Opcode that the block must drop without a result.
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 190;
    // Side of the loaded source corner; random sizes stay inside it.
    localparam int FILL_DIM = 16;
    // Longest pipeline depth plus back end sequencing, with margin.
    localparam int DRAIN_CYCLES = 16;

    // Bit-exact prediction of the rotator: frame store, coordinate walk, blend.
    class rot_scoreboard;
        typedef struct packed {
            logic [23:0] pixel;
            logic        ok;
            logic [11:0] dcol;
            logic [15:0] drow;
            logic        last;
        } t_pixel_exp;

        logic [23:0] frame [irb_pkg::MAX_WIDTH*irb_pkg::MAX_HEIGHT];
        bit [31:0]   row_x, row_y, pix_x, pix_y;
        bit [11:0]   col_cnt;
        bit [15:0]   row_cnt;
        bit [8:0]    width_reg, height_reg;
        bit [12:0]   len_reg;
        bit [31:0]   cos_val, sin_val, start_xv, start_yv;
        t_pixel_exp  pending_pixels [$];
        int          errors;

        function new();
            width_reg = 256; height_reg = 256; len_reg = 256;
            cos_val = 32'd65536; sin_val = 0; start_xv = 0; start_yv = 0;
            row_x = 0; row_y = 0; pix_x = 0; pix_y = 0;
            col_cnt = 0; row_cnt = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, bit [31:0] v);
            case (idx)
                irb_pkg::REG_SRC_WIDTH:  width_reg = v[8:0];
                irb_pkg::REG_SRC_HEIGHT: height_reg = v[8:0];
                irb_pkg::REG_ROW_LENGTH: len_reg = v[12:0];
                irb_pkg::REG_COS_STEP:   cos_val = {{14{v[17]}}, v[17:0]};
                irb_pkg::REG_SIN_STEP:   sin_val = {{14{v[17]}}, v[17:0]};
                irb_pkg::REG_START_X:    start_xv = v;
                irb_pkg::REG_START_Y:    start_yv = v;
                default: ;
            endcase
        endfunction

        // Bilinear blend at the current coordinate; ok low when out of range.
        function void blend(output logic [23:0] pix, output logic ok);
            int unsigned w, h, ix, iy, base;
            bit [63:0] fx, fy, w00, w01, w10, w11, acc, v;
            logic [23:0] p00, p01, p10, p11;
            w = (width_reg > irb_pkg::MAX_WIDTH) ? irb_pkg::MAX_WIDTH : width_reg;
            h = (height_reg > irb_pkg::MAX_HEIGHT) ? irb_pkg::MAX_HEIGHT : height_reg;
            pix = 0;
            ok = 0;
            if (pix_x[31] || pix_y[31]) return;
            ix = pix_x[31:irb_pkg::FRAC_BITS];
            iy = pix_y[31:irb_pkg::FRAC_BITS];
            if (w < 2 || h < 2 || ix >= w - 1 || iy >= h - 1) return;
            fx = pix_x[irb_pkg::FRAC_BITS-1:0];
            fy = pix_y[irb_pkg::FRAC_BITS-1:0];
            w00 = (65536 - fx) * (65536 - fy);
            w01 = fx * (65536 - fy);
            w10 = (65536 - fx) * fy;
            w11 = fx * fy;
            base = iy * irb_pkg::MAX_WIDTH + ix;
            p00 = frame[base];
            p01 = frame[base + 1];
            p10 = frame[base + irb_pkg::MAX_WIDTH];
            p11 = frame[base + irb_pkg::MAX_WIDTH + 1];
            for (int sh = 0; sh < 24; sh += 8) begin
                acc = w00 * p00[sh+:8] + w01 * p01[sh+:8] + w10 * p10[sh+:8]
                    + w11 * p11[sh+:8];
                v = (acc + 64'h8000_0000) >> 32;
                if (v > 255) v = 255;
                pix[sh+:8] = v[7:0];
            end
            ok = 1;
        endfunction

        // Called for every accepted input transaction.
        function void note_input(logic [1:0] op, logic [7:0] col, logic [7:0] row,
                                 logic [23:0] pixel);
            t_pixel_exp e;
            int unsigned len;
            if (op == irb_pkg::OP_LOAD) begin
                frame[row * irb_pkg::MAX_WIDTH + col] = pixel;
            end else if (op == irb_pkg::OP_RESTART) begin
                row_x = start_xv; pix_x = start_xv;
                row_y = start_yv; pix_y = start_yv;
                col_cnt = 0; row_cnt = 0;
            end else if (op == irb_pkg::OP_EMIT) begin
                len = (len_reg == 0) ? 1 : ((len_reg > 4096) ? 4096 : len_reg);
                blend(e.pixel, e.ok);
                e.dcol = col_cnt;
                e.drow = row_cnt;
                e.last = (col_cnt + 1 >= len);
                pending_pixels.push_back(e);
                if (e.last) begin
                    row_x = row_x - sin_val;
                    row_y = row_y + cos_val;
                    pix_x = row_x; pix_y = row_y;
                    col_cnt = 0;
                    row_cnt = row_cnt + 1;
                end else begin
                    pix_x = pix_x + cos_val;
                    pix_y = pix_y + sin_val;
                    col_cnt = col_cnt + 1;
                end
            end
        endfunction

        task report(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function int unsigned pending();
            return pending_pixels.size();
        endfunction

        task check_result(logic [23:0] pixel, logic ok, logic [11:0] dcol,
                          logic [15:0] drow, logic last);
            t_pixel_exp e;
            if (pending_pixels.size() == 0) begin
                report("output transaction with nothing expected");
                return;
            end
            e = pending_pixels.pop_front();
            if (pixel !== e.pixel)
                report($sformatf("out_pixel %h, expected %h", pixel, e.pixel));
            if (ok !== e.ok)
                report($sformatf("in_range %b, expected %b", ok, e.ok));
            if (dcol !== e.dcol)
                report($sformatf("dest_col %0d, expected %0d", dcol, e.dcol));
            if (drow !== e.drow)
                report($sformatf("dest_row %0d, expected %0d", drow, e.drow));
            if (last !== e.last)
                report($sformatf("row_end %b, expected %b", last, e.last));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = 0;
    logic [31:0] i_cfg_data = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    irb_in_if  in_ch();
    irb_out_if out_ch();

    rot_scoreboard rot_sb = new();

    image_rotate_bilinear dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.opcode = irb_pkg::OP_LOAD;
        in_ch.load_col = 0;
        in_ch.load_row = 0;
        in_ch.load_pixel = 0;
        out_ch.ready = 0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Output monitor: every accepted output transaction is checked in order.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            rot_sb.check_result(out_ch.out_pixel, out_ch.in_range, out_ch.dest_col,
                                out_ch.dest_row, out_ch.row_end);
    end

    // Generous cap, far above the corner fill and all stalled phases.
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Drive one input transaction, with optional idle cycles ahead of it.
    // Called right after a rising edge; returns right after the accepting edge.
    task send_item(logic [1:0] op, logic [7:0] col, logic [7:0] row, logic [23:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.opcode <= op;
        in_ch.load_col <= col;
        in_ch.load_row <= row;
        in_ch.load_pixel <= pix;
        do @(posedge i_clk); while (!in_ch.ready);
        rot_sb.note_input(op, col, row, pix);
    endtask

    // Lower valid, wait until all pixels are back, then let the back end drain
    // any trailing loads before the registers are touched.
    task drain_block();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (rot_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write all seven registers back to back; the enable drops after the last.
    task write_config(bit [31:0] vals [7]);
        for (int i = 0; i < 7; i++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= i[2:0];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            rot_sb.set_reg(i[2:0], vals[i]);
        end
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // Sizes stay within the loaded corner so reads never reach unloaded entries.
    function automatic bit [31:0] pick_size();
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return 2;
            3: return FILL_DIM;
            default: return $urandom_range(2, FILL_DIM);
        endcase
    endfunction

    function automatic bit [31:0] pick_step();
        int s;
        case ($urandom_range(5))
            0: s = 65536;
            1: s = -65536;
            2: s = 0;
            default: s = $urandom_range(0, 131072) - 65536;
        endcase
        return s;
    endfunction

    // Random register setting for one phase; start point mostly inside the source.
    function automatic void random_config(ref bit [31:0] vals [7]);
        vals[irb_pkg::REG_SRC_WIDTH]  = pick_size();
        vals[irb_pkg::REG_SRC_HEIGHT] = pick_size();
        case ($urandom_range(7))
            0: vals[irb_pkg::REG_ROW_LENGTH] = 0;
            1: vals[irb_pkg::REG_ROW_LENGTH] = 4096;
            2: vals[irb_pkg::REG_ROW_LENGTH] = 8191;
            default: vals[irb_pkg::REG_ROW_LENGTH] = $urandom_range(1, 24);
        endcase
        vals[irb_pkg::REG_COS_STEP] = pick_step();
        vals[irb_pkg::REG_SIN_STEP] = pick_step();
        if ($urandom_range(9) == 0) begin
            vals[irb_pkg::REG_START_X] = $urandom;
            vals[irb_pkg::REG_START_Y] = $urandom;
        end else begin
            vals[irb_pkg::REG_START_X] = $urandom_range(0, FILL_DIM * 65536);
            vals[irb_pkg::REG_START_Y] = $urandom_range(0, FILL_DIM * 65536);
        end
    endfunction

    initial begin
        bit [31:0] cfg [7];
        int op_roll;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Fill the source corner that every in-range read below stays within.
        for (int r = 0; r < FILL_DIM; r++)
            for (int c = 0; c < FILL_DIM; c++)
                send_item(irb_pkg::OP_LOAD, c[7:0], r[7:0], $urandom);

        // Directed: extreme pixels at the origin, exact and half-way blends,
        // the ignored opcode, default registers and the far corner.
        send_item(irb_pkg::OP_LOAD, 8'd0, 8'd0, 24'h000000);
        send_item(irb_pkg::OP_LOAD, 8'd1, 8'd0, 24'hFFFFFF);
        send_item(irb_pkg::OP_LOAD, 8'd0, 8'd1, 24'hFFFFFF);
        send_item(irb_pkg::OP_LOAD, 8'd1, 8'd1, 24'h000000);
        send_item(irb_pkg::OP_LOAD, 8'd255, 8'd255, 24'hFFFFFF);
        send_item(OP_IGNORED, 8'hFF, 8'hFF, 24'hFFFFFF);
        send_item(irb_pkg::OP_RESTART, 0, 0, 0);
        repeat (3) send_item(irb_pkg::OP_EMIT, 0, 0, 0);
        drain_block();

        // Half steps from the origin, lands on the rounding boundary.
        cfg = '{256, 256, 3, 32768, 32768, 0, 0};
        write_config(cfg);
        send_item(irb_pkg::OP_RESTART, 0, 0, 0);
        repeat (6) send_item(irb_pkg::OP_EMIT, 0, 0, 0);
        drain_block();

        // Negative start, oversized source, zero row length, upper edge.
        cfg = '{511, 511, 0, -65536, 65536, -32768, 254 * 65536 + 1};
        write_config(cfg);
        send_item(irb_pkg::OP_RESTART, 0, 0, 0);
        repeat (4) send_item(irb_pkg::OP_EMIT, 0, 0, 0);
        drain_block();

        // Degenerate source size 1 and 0 leaves every pixel out of range.
        cfg = '{1, 0, 8191, 0, -65536, 0, 0};
        write_config(cfg);
        send_item(irb_pkg::OP_RESTART, 0, 0, 0);
        repeat (3) send_item(irb_pkg::OP_EMIT, 0, 0, 0);
        drain_block();

        // Random phases, cycling through the four idle/stall profiles.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            random_config(cfg);
            write_config(cfg);
            // Skipping the restart now and then keeps a row open across a
            // row length change.
            if ($urandom_range(3) != 0) send_item(irb_pkg::OP_RESTART, 0, 0, 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op_roll = $urandom_range(99);
                if (op_roll < 70)
                    send_item(irb_pkg::OP_EMIT, $urandom, $urandom, $urandom);
                else if (op_roll < 88)
                    send_item(irb_pkg::OP_LOAD, $urandom, $urandom, $urandom);
                else if (op_roll < 96)
                    send_item(irb_pkg::OP_RESTART, $urandom, $urandom, $urandom);
                else
                    send_item(OP_IGNORED, $urandom, $urandom, $urandom);
            end
            drain_block();
        end

        if (rot_sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> image_rotate_bilinear.f
+incdir+hdl
hdl/irb_pkg.sv
hdl/irb_if.sv
hdl/irb_front.sv
hdl/irb_fifo.sv
hdl/irb_bank.sv
hdl/irb_back.sv
hdl/image_rotate_bilinear.sv
hdl/irb_checker.sv
verif/testbench.sv
